FILE: hdl/xtea_pkg.sv
// Shared types, constants and round helper for the XTEA block cipher.
// No dependencies; every other file in hdl refers to it by scoped names.
package xtea_pkg;

  localparam logic [31:0] DELTA = 32'h9E37_79B9;
  localparam int unsigned HalfW = 32;
  localparam int unsigned RndW  = 8;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_KEY0   = 3'd0,
    CFG_KEY1   = 3'd1,
    CFG_KEY2   = 3'd2,
    CFG_KEY3   = 3'd3,
    CFG_ROUNDS = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIN
  } ctrl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the accepted item
    logic step;   // perform one half-round
    logic phase;  // 0: first half-round of a cycle, 1: second
    logic push;   // copy the finished block into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [RndW-1:0] round_count;
  } dp_status_t;

  // XTEA mixing function: ((x << 4) ^ (x >> 5)) + x.
  function automatic logic [HalfW-1:0] mix(input logic [HalfW-1:0] x);
    logic [HalfW-1:0] t;
    t = (x << 4) ^ (x >> 5);
    return t + x;
  endfunction

endpackage

FILE: hdl/xtea_dp.sv
// Datapath of the XTEA block cipher: key and round registers, block halves,
// running sum, one half-round unit and the output register. Uses xtea_pkg.
module xtea_dp (
  input  logic                       clk,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic                       rst_n,
  input  xtea_pkg::ctrl_cmd_t        cmd,
  output xtea_pkg::dp_status_t       status,
  input  logic                       in_mode,
  input  logic [xtea_pkg::HalfW-1:0] in_left,
  input  logic [xtea_pkg::HalfW-1:0] in_right,
  output logic [xtea_pkg::HalfW-1:0] out_left,
  output logic [xtea_pkg::HalfW-1:0] out_right
);

  logic [xtea_pkg::HalfW-1:0] key_r [4];
  logic [xtea_pkg::RndW-1:0]  rounds_r;
  logic [xtea_pkg::HalfW-1:0] dec_sum_r;
  logic [xtea_pkg::HalfW-1:0] a_r, b_r, s_r;
  logic                       mode_r;
  logic [xtea_pkg::HalfW-1:0] out_left_r, out_right_r;

  logic [xtea_pkg::HalfW+xtea_pkg::RndW-1:0] dec_prod;
  logic                       tgt_b;
  logic [xtea_pkg::HalfW-1:0] src, tgt, mixed, keyed, upd, kw;
  logic [1:0]                 ksel;

  // Start sum for decryption follows the round count, so it is worked out
  // when the round count is written.
  assign dec_prod = (xtea_pkg::HalfW + xtea_pkg::RndW)'(xtea_pkg::DELTA)
                  * (xtea_pkg::HalfW + xtea_pkg::RndW)'(cfg_data[xtea_pkg::RndW-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r[0]  <= '0;
      key_r[1]  <= '0;
      key_r[2]  <= '0;
      key_r[3]  <= '0;
      rounds_r  <= xtea_pkg::RndW'(32);
      dec_sum_r <= 32'hC6EF_3720;
    end else if (cfg_we) begin
      unique case (xtea_pkg::cfg_reg_t'(cfg_index))
        xtea_pkg::CFG_KEY0: key_r[0] <= cfg_data;
        xtea_pkg::CFG_KEY1: key_r[1] <= cfg_data;
        xtea_pkg::CFG_KEY2: key_r[2] <= cfg_data;
        xtea_pkg::CFG_KEY3: key_r[3] <= cfg_data;
        xtea_pkg::CFG_ROUNDS: begin
          rounds_r  <= cfg_data[xtea_pkg::RndW-1:0];
          dec_sum_r <= dec_prod[xtea_pkg::HalfW-1:0];
        end
        default: ;
      endcase
    end
  end

  assign status.round_count = rounds_r;

  // The half that changes alternates; decryption runs the halves in the
  // opposite order, which also picks the upper selector bits of the sum.
  assign tgt_b = mode_r ^ cmd.phase;
  assign src   = tgt_b ? a_r : b_r;
  assign tgt   = tgt_b ? b_r : a_r;
  assign ksel  = tgt_b ? s_r[12:11] : s_r[1:0];
  assign kw    = key_r[ksel];
  assign mixed = xtea_pkg::mix(src);
  assign keyed = mixed ^ (s_r + kw);
  assign upd   = mode_r ? (tgt - keyed) : (tgt + keyed);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_r    <= in_left;
      b_r    <= in_right;
      mode_r <= in_mode;
      s_r    <= in_mode ? dec_sum_r : '0;
    end else if (cmd.step) begin
      if (tgt_b) begin
        b_r <= upd;
      end else begin
        a_r <= upd;
      end
      if (!cmd.phase) begin
        s_r <= mode_r ? (s_r - xtea_pkg::DELTA) : (s_r + xtea_pkg::DELTA);
      end
    end
    if (cmd.push) begin
      out_left_r  <= a_r;
      out_right_r <= b_r;
    end
  end

  assign out_left  = out_left_r;
  assign out_right = out_right_r;

endmodule

FILE: hdl/xtea_ctrl.sv
// Controller of the XTEA block cipher: sequences half-rounds and owns the
// input and output handshakes. Uses xtea_pkg.
module xtea_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  xtea_pkg::dp_status_t status,
  output xtea_pkg::ctrl_cmd_t  cmd
);

  xtea_pkg::ctrl_state_t       state_r, state_nxt;
  logic [xtea_pkg::RndW-1:0]   cnt_r, cnt_nxt;
  logic                        phase_r, phase_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= xtea_pkg::ST_IDLE;
      cnt_r       <= '0;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.phase     = phase_r;
    in_ready      = 1'b0;
    unique case (state_r)
      xtea_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = status.round_count;
          phase_nxt = 1'b0;
          state_nxt = (status.round_count == '0) ? xtea_pkg::ST_FIN : xtea_pkg::ST_RUN;
        end
      end
      xtea_pkg::ST_RUN: begin
        cmd.step  = 1'b1;
        phase_nxt = !phase_r;
        if (phase_r) begin
          cnt_nxt = cnt_r - xtea_pkg::RndW'(1);
          if (cnt_r == xtea_pkg::RndW'(1)) begin
            state_nxt = xtea_pkg::ST_FIN;
          end
        end
      end
      xtea_pkg::ST_FIN: begin
        if (out_free) begin
          cmd.push      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = xtea_pkg::ST_IDLE;
        end
      end
      default: state_nxt = xtea_pkg::ST_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hdl/xtea_block_cipher_top.sv
// XTEA block cipher, one 64-bit block per item. After acceptance the item runs
// round_count rounds, one half-round per cycle in a single shared round unit,
// then goes to the output register; the next item is taken only after that.
// Synchronous active-low reset: keys clear to zero, round_count to 32, the
// controller idles and no result is shown. No clearing pass is needed.
// Depends on xtea_pkg, xtea_ctrl and xtea_dp.
module xtea_block_cipher_top (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] block_left, [63:32] block_right
  input  logic [0:0]  in_tuser,   // [0] mode: 0 encrypt, 1 decrypt
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // [31:0] result_left, [63:32] result_right
  // Configuration writes: 0..3 key words, 4 round count, others ignored.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  xtea_pkg::ctrl_cmd_t  cmd;
  xtea_pkg::dp_status_t status;
  logic [xtea_pkg::HalfW-1:0] res_left, res_right;

  // Register writes are always taken; the user must issue them only while idle (not enforced here).
  assign cfg_ready = 1'b1;

  // The controller walks through the rounds and holds the output valid flag,
  // so a new item is taken while a finished result still waits.
  xtea_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .status    (status),
    .cmd       (cmd)
  );

  // The datapath holds the key, the block halves, the running sum and the
  // output register, and applies one half-round per step command.
  xtea_dp u_dp (
    .clk       (clk),
    .cfg_we    (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_mode   (in_tuser[0]),
    .in_left   (in_tdata[31:0]),
    .in_right  (in_tdata[63:32]),
    .out_left  (res_left),
    .out_right (res_right)
  );

  assign out_tdata = {res_right, res_left};

endmodule
